// ===== design/float_bit_mutate_crossover_macros.svh =====
// Assertion macros used by the float bit mutate and crossover top-level file.
`ifndef FLOAT_BIT_MUTATE_CROSSOVER_MACROS_SVH
`define FLOAT_BIT_MUTATE_CROSSOVER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on clk and disabled while arst_n is low.
`define FBMC_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked on clk and disabled while arst_n is low.
`define FBMC_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FBMC_ASSERT_IMP(name, ante, cons, msg)
`define FBMC_ASSERT_NXT(name, ante, cons, msg)
`endif
`endif

// ===== design/fbmc_pkg.sv =====
// Shared types and constants of the float bit mutate and crossover block.
package fbmc_pkg;

	localparam int MAX_RETRIES = 16;
	localparam int RETRY_W = $clog2(MAX_RETRIES + 1);

	localparam int WORD_W = 64;
	localparam int WEIGHT_W = 16;
	localparam int SEED_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int FRAC_W = 16;
	localparam int K_W = 18;
	localparam int PROD_W = FRAC_W + K_W;
	localparam int BIT_IDX_W = 6;

	localparam logic [CFG_IDX_W-1:0] CFG_SIGN_WEIGHT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXP_WEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MANT_WEIGHT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED = 2'd3;

	localparam logic [WEIGHT_W-1:0] SIGN_WEIGHT_RST = 16'd4096;
	localparam logic [WEIGHT_W-1:0] EXP_WEIGHT_RST = 16'd8192;
	localparam logic [WEIGHT_W-1:0] MANT_WEIGHT_RST = 16'd53248;
	localparam logic [SEED_W-1:0] SEED_RST = 32'd1;

	typedef struct packed {
		logic command;
		logic double_precision;
		logic [WORD_W-1:0] operand_a;
		logic [WORD_W-1:0] operand_b;
	} fbmc_in_t;

	typedef struct packed {
		logic [WORD_W-1:0] result_bits;
		logic gave_up;
	} fbmc_out_t;

	// Controller to datapath.
	typedef struct packed {
		logic load_in;
		logic draw;
		logic sect_draw;
		logic sect_eval;
		logic bit_eval;
		logic give_up;
		logic load_out;
	} fbmc_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic sect_final;
		logic bit_ok;
	} fbmc_stat_t;

endpackage

// ===== design/fbmc_datapath.sv =====
// Datapath: configuration, xorshift generator, scaled picks and bit manipulation.
module fbmc_datapath (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [fbmc_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [fbmc_pkg::CFG_DATA_W-1:0] cfg_data,
	input fbmc_pkg::fbmc_in_t in_word,
	input fbmc_pkg::fbmc_cmd_t cmd,
	output fbmc_pkg::fbmc_stat_t stat,
	output fbmc_pkg::fbmc_out_t out_word
);
	import fbmc_pkg::*;

	typedef enum logic [1:0] {
		MODE_EXP = 2'd0,
		MODE_MANT = 2'd1,
		MODE_CROSS = 2'd2
	} mode_t;

	logic [WEIGHT_W-1:0] sign_w_q, exp_w_q, mant_w_q;
	logic [SEED_W-1:0] gen_q;
	logic [WORD_W-1:0] a_q, b_q, res_q;
	logic dbl_q, gave_q;
	mode_t mode_q;
	logic [PROD_W-1:0] prod_q;
	fbmc_out_t out_q;

	logic [SEED_W-1:0] x1, x2, gen_next;
	logic [FRAC_W-1:0] frac;
	logic [K_W-1:0] total, k;
	logic [PROD_W-1:0] prod_next, lim_s, lim_e;
	logic [WEIGHT_W:0] sum_se;
	logic a_special, pick_sign, pick_exp;
	logic [WORD_W-1:0] sign_mask, cut_mask, flip_n, cross_n, cand, a_in, b_in;
	logic [BIT_IDX_W-1:0] idx, exp_base, bit_pos;
	logic exp_all;
	logic sect_final, bit_ok;

	always_comb begin
		x1 = gen_q ^ (gen_q << 13);
		x2 = x1 ^ (x1 >> 17);
		gen_next = x2 ^ (x2 << 5);
		frac = gen_next[SEED_W-1:SEED_W-FRAC_W];
		total = K_W'(sign_w_q) + K_W'(exp_w_q) + K_W'(mant_w_q);
		if (cmd.sect_draw) begin
			k = total;
		end else begin
			case (mode_q)
				MODE_CROSS: k = dbl_q ? K_W'(64) : K_W'(32);
				MODE_EXP: k = dbl_q ? K_W'(11) : K_W'(8);
				MODE_MANT: k = dbl_q ? K_W'(52) : K_W'(23);
				default: k = dbl_q ? K_W'(52) : K_W'(23);
			endcase
		end
		prod_next = {{K_W{1'b0}}, frac} * {{FRAC_W{1'b0}}, k};
	end

	// Section choice from the registered product of the first draw.
	always_comb begin
		sum_se = {1'b0, sign_w_q} + {1'b0, exp_w_q};
		lim_s = {2'b00, sign_w_q, {FRAC_W{1'b0}}};
		lim_e = {1'b0, sum_se, {FRAC_W{1'b0}}};
		a_special = !dbl_q && (&a_q[30:23]);
		pick_sign = prod_q < lim_s;
		pick_exp = prod_q < lim_e;
		sign_mask = dbl_q ? {1'b1, {(WORD_W-1){1'b0}}} : {{(WORD_W/2){1'b0}}, 1'b1,
			{(WORD_W/2-1){1'b0}}};
		sect_final = a_special || pick_sign;
	end

	// Candidate offspring from the registered product of a bit or cut draw.
	always_comb begin
		idx = prod_q[FRAC_W +: BIT_IDX_W];
		exp_base = dbl_q ? BIT_IDX_W'(52) : BIT_IDX_W'(23);
		bit_pos = (mode_q == MODE_EXP) ? idx + exp_base : idx;
		flip_n = a_q ^ ({{(WORD_W-1){1'b0}}, 1'b1} << bit_pos);
		cut_mask = {WORD_W{1'b1}} << idx;
		cross_n = (a_q & cut_mask) | (b_q & ~cut_mask);
		cand = (mode_q == MODE_CROSS) ? cross_n : flip_n;
		exp_all = dbl_q ? (&cand[62:52]) : (&cand[30:23]);
		bit_ok = (mode_q == MODE_MANT) || !exp_all;
	end

	assign stat = '{sect_final: sect_final, bit_ok: bit_ok};

	always_comb begin
		a_in = in_word.double_precision ? in_word.operand_a
			: {{(WORD_W/2){1'b0}}, in_word.operand_a[WORD_W/2-1:0]};
		b_in = in_word.double_precision ? in_word.operand_b
			: {{(WORD_W/2){1'b0}}, in_word.operand_b[WORD_W/2-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sign_w_q <= SIGN_WEIGHT_RST;
			exp_w_q <= EXP_WEIGHT_RST;
			mant_w_q <= MANT_WEIGHT_RST;
			gen_q <= SEED_RST;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SIGN_WEIGHT: sign_w_q <= cfg_data[WEIGHT_W-1:0];
					CFG_EXP_WEIGHT: exp_w_q <= cfg_data[WEIGHT_W-1:0];
					CFG_MANT_WEIGHT: mant_w_q <= cfg_data[WEIGHT_W-1:0];
					CFG_RANDOM_SEED: begin
						// A zero seed would lock the generator at zero.
						gen_q <= (cfg_data == '0) ? SEED_RST : cfg_data[SEED_W-1:0];
					end
					default: ;
				endcase
			end else if (cmd.draw) begin
				gen_q <= gen_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.draw) begin
			prod_q <= prod_next;
		end
		if (cmd.load_in) begin
			a_q <= a_in;
			b_q <= b_in;
			dbl_q <= in_word.double_precision;
			mode_q <= in_word.command ? MODE_CROSS : MODE_MANT;
			res_q <= a_in;
			gave_q <= 1'b0;
		end
		if (cmd.sect_eval) begin
			mode_q <= pick_exp ? MODE_EXP : MODE_MANT;
			if (!a_special && pick_sign) begin
				res_q <= a_q ^ sign_mask;
			end
		end
		if (cmd.bit_eval && bit_ok) begin
			res_q <= cand;
		end
		if (cmd.give_up) begin
			gave_q <= 1'b1;
		end
		if (cmd.load_out) begin
			out_q.result_bits <= res_q;
			out_q.gave_up <= gave_q;
		end
	end

	assign out_word = out_q;

endmodule

// ===== design/fbmc_ctrl.sv =====
// Controller: sequences draws, evaluations, retries and the output register.
module fbmc_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic command,
	input logic out_stall,
	input fbmc_pkg::fbmc_stat_t stat,
	output logic in_stall,
	output logic out_valid,
	output fbmc_pkg::fbmc_cmd_t cmd
);
	import fbmc_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SECT = 6'b000010,
		S_SECT_EV = 6'b000100,
		S_BIT = 6'b001000,
		S_BIT_EV = 6'b010000,
		S_OUT = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic [RETRY_W-1:0] tries_q;
	logic out_valid_q;
	logic last_try;

	assign last_try = (tries_q == RETRY_W'(MAX_RETRIES - 1));

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = command ? S_BIT : S_SECT;
				end
			end
			S_SECT: begin
				cmd.draw = 1'b1;
				cmd.sect_draw = 1'b1;
				state_d = S_SECT_EV;
			end
			S_SECT_EV: begin
				cmd.sect_eval = 1'b1;
				state_d = stat.sect_final ? S_OUT : S_BIT;
			end
			S_BIT: begin
				cmd.draw = 1'b1;
				state_d = S_BIT_EV;
			end
			S_BIT_EV: begin
				cmd.bit_eval = 1'b1;
				if (stat.bit_ok) begin
					state_d = S_OUT;
				end else if (last_try) begin
					cmd.give_up = 1'b1;
					state_d = S_OUT;
				end else begin
					state_d = S_BIT;
				end
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tries_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_in || cmd.sect_eval) begin
				tries_q <= '0;
			end else if (cmd.bit_eval && !stat.bit_ok && !last_try) begin
				tries_q <= tries_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== design/float_bit_mutate_crossover.sv =====
// Top level of the float bit mutate and crossover block.
// Usage:
// The input channel carries one word per item: a command (mutate or crossover),
// the precision flag and two raw IEEE-754 operands. The output channel returns
// one word per item: the offspring bits and a gave_up flag. Configuration is a
// plain write port for the three section weights and the generator seed; the
// user must see that it is written only while the block is idle, which the block
// itself does not enforce, and a seed write reloads the generator. Each attempt
// is a generator step with its scaled multiply, then an evaluation of the
// registered product. A sign flip, a passed-through single infinity or NaN, or
// a crossover that succeeds at once ends after its first attempt; a mantissa or
// exponent flip draws a bit after the section draw. Every rejected exponent or
// crossover attempt adds another, up to the cap of MAX_RETRIES attempts. The
// result is in the output register by the time the next word can be accepted.
// The next item is accepted while the result waits, but a further result waits
// in the controller until the receiver drops stall. Reset loads the default
// weights, seeds the generator with one and empties the output register.
`include "float_bit_mutate_crossover_macros.svh"
module float_bit_mutate_crossover (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input fbmc_pkg::fbmc_in_t in_word,
	output logic out_valid,
	input logic out_stall,
	output fbmc_pkg::fbmc_out_t out_word,
	input logic cfg_we,
	input logic [fbmc_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [fbmc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fbmc_pkg::*;

	fbmc_cmd_t cmd;
	fbmc_stat_t stat;

	fbmc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.command(in_word.command),
		.out_stall(out_stall),
		.stat(stat),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.cmd(cmd)
	);

	fbmc_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_word(in_word),
		.cmd(cmd),
		.stat(stat),
		.out_word(out_word)
	);

	`FBMC_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accept did not stall")
	`FBMC_ASSERT_IMP(a_give_up_only_on_fail, cmd.give_up, cmd.bit_eval && !stat.bit_ok, "bad give up")
	`FBMC_ASSERT_NXT(a_load_sets_valid, cmd.load_out, out_valid, "result not presented")

endmodule
